// File: hdl/pffl_pkg.sv
// pffl_pkg: widths, codes and shared types of the page frame free lists
// no dependencies
`timescale 1ns / 1ps

package pffl_pkg;

  localparam int FRAMES  = 4096;
  localparam int IDX_W   = $clog2(FRAMES);
  localparam int LINK_W  = $clog2(FRAMES + 1);
  localparam int FRAME_W = 20;
  localparam int COUNT_W = 13;

  // link or head value that marks the end of a list
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(FRAMES);

  // kind field: bit 1 set means pop, bit 0 picks the zeroed list
  localparam int KIND_POP_BIT  = 1;
  localparam int KIND_LIST_BIT = 0;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic issue;
    logic finish;
  } cmd_t;

endpackage

// File: hdl/pffl_ctrl.sv
// pffl_ctrl: two-state controller, issue phase then finish phase
// depends on pffl_pkg
`timescale 1ns / 1ps

module pffl_ctrl
  import pffl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:   state_next = start ? ST_FINISH : ST_IDLE;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.issue  = start;
        cmd.finish = 1'b0;
      end
      ST_FINISH: begin
        busy       = 1'b1;
        cmd.issue  = 1'b0;
        cmd.finish = 1'b1;
      end
      default: begin
        busy       = 1'b0;
        cmd.issue  = 1'b0;
        cmd.finish = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/pffl_datapath.sv
// pffl_datapath: link store, list heads and tails, counts and result registers
// depends on pffl_pkg; driven by commands from pffl_ctrl
`timescale 1ns / 1ps

module pffl_datapath
  import pffl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         kind,
  input  logic [FRAME_W-1:0] frame,
  input  logic               cfg_write,
  input  logic [FRAME_W-1:0] cfg_data,
  output logic [FRAME_W-1:0] frame_out,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] free_list_count,
  output logic [COUNT_W-1:0] zeroed_list_count,
  output logic [COUNT_W-1:0] available_pages
);

  logic [LINK_W-1:0] next_link [FRAMES];
  logic [LINK_W-1:0] link_rd;

  logic [FRAME_W-1:0] lowest_frame;
  logic [LINK_W-1:0]  free_head, free_tail, zeroed_head, zeroed_tail;
  logic [LINK_W-1:0]  free_total, zeroed_total, available_total;

  // operation held from issue to finish
  logic             op_pop;
  logic             op_list;
  logic             op_ok;
  logic [IDX_W-1:0] op_idx;

  logic [FRAME_W-1:0] idx_full;
  logic               in_range;
  logic [IDX_W-1:0]   idx_in;
  logic               pop_in;
  logic               list_now;
  logic [LINK_W-1:0]  head_cur, tail_cur;
  logic               head_valid, tail_valid;
  logic               link_end;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [LINK_W-1:0] mem_wdata;

  assign idx_full = frame - lowest_frame;
  assign in_range = {1'b0, idx_full} < (FRAME_W + 1)'(FRAMES);
  assign idx_in   = idx_full[IDX_W-1:0];
  assign pop_in   = kind[KIND_POP_BIT];

  assign list_now   = cmd.issue ? kind[KIND_LIST_BIT] : op_list;
  assign head_cur   = list_now ? zeroed_head : free_head;
  assign tail_cur   = list_now ? zeroed_tail : free_tail;
  assign head_valid = head_cur < LINK_NONE;
  assign tail_valid = tail_cur < LINK_NONE;
  assign link_end   = link_rd >= LINK_NONE;

  // issue: append clears the new entry's link, pop reads the head's link
  // finish: append points the old tail at the new entry, pop clears the
  // old head's link
  always_comb begin
    if (cmd.issue) begin
      mem_we    = !pop_in && in_range;
      mem_addr  = pop_in ? head_cur[IDX_W-1:0] : idx_in;
      mem_wdata = LINK_NONE;
    end else begin
      mem_we    = cmd.finish && op_ok && (op_pop || tail_valid);
      mem_addr  = op_pop ? head_cur[IDX_W-1:0] : tail_cur[IDX_W-1:0];
      mem_wdata = op_pop ? LINK_NONE : LINK_W'(op_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_addr] <= mem_wdata;
    end
    link_rd <= next_link[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_pop  <= pop_in;
      op_list <= kind[KIND_LIST_BIT];
      op_ok   <= pop_in ? head_valid : in_range;
      op_idx  <= idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op_pop && op_ok) begin
        frame_out <= FRAME_W'(head_cur[IDX_W-1:0]) + lowest_frame;
      end else begin
        frame_out <= '0;
      end
      if (op_ok) begin
        status <= STATUS_OK;
      end else if (op_pop) begin
        status <= STATUS_EMPTY;
      end else begin
        status <= STATUS_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_frame    <= '0;
      free_head       <= LINK_NONE;
      free_tail       <= LINK_NONE;
      zeroed_head     <= LINK_NONE;
      zeroed_tail     <= LINK_NONE;
      free_total      <= '0;
      zeroed_total    <= '0;
      available_total <= '0;
    end else begin
      if (cfg_write) begin
        lowest_frame <= cfg_data;
      end
      if (cmd.finish && op_ok) begin
        if (!op_pop) begin
          if (available_total < LINK_NONE) begin
            available_total <= available_total + 1'b1;
          end
          if (op_list) begin
            if (!tail_valid) begin
              zeroed_head <= LINK_W'(op_idx);
            end
            zeroed_tail <= LINK_W'(op_idx);
            if (zeroed_total < LINK_NONE) begin
              zeroed_total <= zeroed_total + 1'b1;
            end
          end else begin
            if (!tail_valid) begin
              free_head <= LINK_W'(op_idx);
            end
            free_tail <= LINK_W'(op_idx);
            if (free_total < LINK_NONE) begin
              free_total <= free_total + 1'b1;
            end
          end
        end else begin
          if (available_total != '0) begin
            available_total <= available_total - 1'b1;
          end
          if (op_list) begin
            zeroed_head <= link_end ? LINK_NONE : link_rd;
            if (link_end) begin
              zeroed_tail <= LINK_NONE;
            end
            if (zeroed_total != '0) begin
              zeroed_total <= zeroed_total - 1'b1;
            end
          end else begin
            free_head <= link_end ? LINK_NONE : link_rd;
            if (link_end) begin
              free_tail <= LINK_NONE;
            end
            if (free_total != '0) begin
              free_total <= free_total - 1'b1;
            end
          end
        end
      end
    end
  end

  // counts settle at the finish edge and hold until the next finish
  assign free_list_count   = COUNT_W'(free_total);
  assign zeroed_list_count = COUNT_W'(zeroed_total);
  assign available_pages   = COUNT_W'(available_total);

endmodule

// File: hdl/page_frame_free_lists.sv
// page_frame_free_lists: top level, controller plus datapath
// depends on pffl_pkg, pffl_ctrl, pffl_datapath
`timescale 1ns / 1ps
//
// channel   direction  transfer marked by   payload
// command   in         start && !busy        kind, frame
// result    out        done (one cycle)      frame_out, status, free_list_count,
//                                            zeroed_list_count, available_pages
// config    in         cfg_write             cfg_data (lowest frame)
//
// every item makes an issue access to the single-port link store, then a finish
// access; busy is high during the finish access
// done rises at the edge where busy falls, so a new command can transfer in the
// same cycle as the previous result
// synchronous active-high reset clears lists and counts; the link store is not
// cleared, entries are always written before they are read
// the receiver cannot stall, results are never held back

module page_frame_free_lists
  import pffl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [FRAME_W-1:0] frame,
  input  logic               cfg_write,
  input  logic [FRAME_W-1:0] cfg_data,
  output logic               done,
  output logic [FRAME_W-1:0] frame_out,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] free_list_count,
  output logic [COUNT_W-1:0] zeroed_list_count,
  output logic [COUNT_W-1:0] available_pages
);

  cmd_t cmd;

  pffl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  pffl_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .kind              (kind),
    .frame             (frame),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .frame_out         (frame_out),
    .status            (status),
    .free_list_count   (free_list_count),
    .zeroed_list_count (zeroed_list_count),
    .available_pages   (available_pages)
  );

endmodule

// File: hdl/pffl_checker.sv
// pffl_checker: port-level timing and result checks, bound to the top level
// depends on pffl_pkg and page_frame_free_lists
`timescale 1ns / 1ps

module pffl_checker
  import pffl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [FRAME_W-1:0] frame_out,
  input logic [1:0]         status
);

  // a transfer leads to busy, then to a result at the edge where busy falls
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 done)
    else $error("result not delivered two cycles after command transfer");

  assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (frame_out == '0))
    else $error("failed item reports a nonzero frame");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_OK || status == STATUS_EMPTY || status == STATUS_RANGE))
    else $error("undefined status code");

endmodule

bind page_frame_free_lists pffl_checker u_pffl_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .frame_out (frame_out),
  .status    (status)
);

// File: tb/page_frame_free_lists_checker.sv
// page_frame_free_lists_checker: mirrors both frame lists and checks every result
// depends on pffl_pkg; watches the command, config and result ports of the block
`timescale 1ns / 1ps

module page_frame_free_lists_checker
  import pffl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic [FRAME_W-1:0] frame,
  input  logic               cfg_write,
  input  logic [FRAME_W-1:0] cfg_data,
  input  logic               done,
  input  logic [FRAME_W-1:0] frame_out,
  input  logic [1:0]         status,
  input  logic [COUNT_W-1:0] free_list_count,
  input  logic [COUNT_W-1:0] zeroed_list_count,
  input  logic [COUNT_W-1:0] available_pages,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] zeroed_count;
    logic [COUNT_W-1:0] avail_count;
  } list_report_t;

  list_report_t       pending_reports[$];

  // index 0 is the free list, index 1 the zeroed list
  logic [LINK_W-1:0]  link_mem [FRAMES];
  logic [LINK_W-1:0]  head [2];
  logic [LINK_W-1:0]  tail [2];
  logic [COUNT_W-1:0] total [2];
  logic [COUNT_W-1:0] avail;
  logic [FRAME_W-1:0] lowest;

  function automatic list_report_t apply_list_op(input logic [1:0] k,
                                                 input logic [FRAME_W-1:0] f);
    list_report_t      r;
    logic [FRAME_W-1:0] idx;
    logic [LINK_W-1:0]  h;
    int                 l;
    r = '0;
    r.status = STATUS_OK;
    l = k[KIND_LIST_BIT];
    if (!k[KIND_POP_BIT]) begin
      idx = f - lowest;
      if (idx >= FRAMES) begin
        r.status = STATUS_RANGE;
      end else begin
        link_mem[idx[IDX_W-1:0]] = LINK_NONE;
        if (tail[l] != LINK_NONE) begin
          link_mem[tail[l][IDX_W-1:0]] = LINK_W'(idx);
        end else begin
          head[l] = LINK_W'(idx);
        end
        tail[l] = LINK_W'(idx);
        if (total[l] < FRAMES) total[l]++;
        if (avail < FRAMES) avail++;
      end
    end else begin
      h = head[l];
      if (h >= FRAMES) begin
        r.status = STATUS_EMPTY;
      end else begin
        head[l] = link_mem[h[IDX_W-1:0]];
        if (head[l] >= FRAMES) begin
          head[l] = LINK_NONE;
          tail[l] = LINK_NONE;
        end
        link_mem[h[IDX_W-1:0]] = LINK_NONE;
        // counts floor at zero even if a head survives a duplicate append
        if (total[l] > 0) total[l]--;
        if (avail > 0) avail--;
        r.frame_out = lowest + FRAME_W'(h);
      end
    end
    r.free_count   = total[0];
    r.zeroed_count = total[1];
    r.avail_count  = avail;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [FRAME_W-1:0] want_v,
                             input logic [FRAME_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    list_report_t want;
    if (rst) begin
      lowest   = '0;
      head     = '{LINK_NONE, LINK_NONE};
      tail     = '{LINK_NONE, LINK_NONE};
      total    = '{'0, '0};
      avail    = '0;
      failures = 0;
      pending_reports.delete();
    end else begin
      if (done) begin
        if (pending_reports.size() == 0) begin
          $error("result with no command outstanding: frame_out %0h status %0d",
                 frame_out, status);
          failures++;
        end else begin
          want = pending_reports.pop_front();
          check_field("frame_out", want.frame_out, frame_out);
          check_field("status", FRAME_W'(want.status), FRAME_W'(status));
          check_field("free_list_count", FRAME_W'(want.free_count),
                      FRAME_W'(free_list_count));
          check_field("zeroed_list_count", FRAME_W'(want.zeroed_count),
                      FRAME_W'(zeroed_list_count));
          check_field("available_pages", FRAME_W'(want.avail_count),
                      FRAME_W'(available_pages));
        end
      end
      // command transfer
      if (start && !busy) pending_reports.push_back(apply_list_op(kind, frame));
      if (cfg_write) lowest = cfg_data;
    end
    pending = pending_reports.size();
  end

endmodule

// File: tb/page_frame_free_lists_test.sv
// page_frame_free_lists_test: drives list commands and lowest-frame settings
// depends on pffl_pkg, page_frame_free_lists and page_frame_free_lists_checker
`timescale 1ns / 1ps

module page_frame_free_lists_test;
  import pffl_pkg::*;

  localparam logic [1:0] KIND_ADD_FREE   = 2'd0;
  localparam logic [1:0] KIND_ADD_ZEROED = 2'd1;
  localparam logic [1:0] KIND_POP_FREE   = 2'd2;
  localparam logic [1:0] KIND_POP_ZEROED = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic [1:0]         kind      = KIND_ADD_FREE;
  logic [FRAME_W-1:0] frame     = '0;
  logic               cfg_write = 1'b0;
  logic [FRAME_W-1:0] cfg_data  = '0;
  logic               busy;
  logic               done;
  logic [FRAME_W-1:0] frame_out;
  logic [1:0]         status;
  logic [COUNT_W-1:0] free_list_count;
  logic [COUNT_W-1:0] zeroed_list_count;
  logic [COUNT_W-1:0] available_pages;
  int                 failures;
  int                 pending;

  logic [FRAME_W-1:0] cur_lowest = '0;
  logic [IDX_W-1:0]   fresh_idx;
  logic [IDX_W-1:0]   recent [8] = '{default: '0};
  bit                 idle_on;

  always #1 clk = ~clk;

  page_frame_free_lists uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .frame             (frame),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .done              (done),
    .frame_out         (frame_out),
    .status            (status),
    .free_list_count   (free_list_count),
    .zeroed_list_count (zeroed_list_count),
    .available_pages   (available_pages)
  );

  page_frame_free_lists_checker list_watch (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .kind              (kind),
    .frame             (frame),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .done              (done),
    .frame_out         (frame_out),
    .status            (status),
    .free_list_count   (free_list_count),
    .zeroed_list_count (zeroed_list_count),
    .available_pages   (available_pages),
    .failures          (failures),
    .pending           (pending)
  );

  task automatic send(input logic [1:0] k, input logic [FRAME_W-1:0] f);
    @(negedge clk);
    start <= 1'b1;
    kind  <= k;
    frame <= f;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    kind  <= 2'($urandom);
    frame <= FRAME_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // register writes only once every result is back and the block is quiet
  task automatic set_lowest(input logic [FRAME_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_lowest = v;
  endtask

  task automatic random_item(input int add_pct);
    logic [1:0]         k;
    logic [FRAME_W-1:0] f;
    logic [IDX_W-1:0]   idx;
    int                 pick;
    k = ($urandom_range(99) < add_pct) ? KIND_ADD_FREE : KIND_POP_FREE;
    if ($urandom_range(1)) k = (k == KIND_ADD_FREE) ? KIND_ADD_ZEROED : KIND_POP_ZEROED;
    pick = $urandom_range(99);
    idx  = fresh_idx;
    if (pick < 70) begin
      // frames not yet handed out, so lists stay well formed
      fresh_idx = fresh_idx + IDX_W'($urandom_range(1, 3));
    end else if (pick < 82) begin
      idx = recent[$urandom_range(7)];
    end else if (pick < 88) begin
      idx = IDX_W'($urandom);
    end
    f = cur_lowest + FRAME_W'(idx);
    if (pick >= 97) f = cur_lowest - 1'b1;
    else if (pick >= 94) f = cur_lowest + FRAME_W'(FRAMES);
    else if (pick >= 88) f = FRAME_W'($urandom);
    if (k[KIND_POP_BIT]) f = FRAME_W'($urandom);
    else if (pick < 88) recent[$urandom_range(7)] = idx;
    if (idle_on && $urandom_range(99) < 25) pause($urandom_range(1, 11));
    send(k, f);
  endtask

  task automatic random_phase(input int items, input int add_pct, input bit idling);
    for (int i = 0; i < items; i++) begin
      if (i % 25 == 0) idle_on = idling && ($urandom_range(3) != 0);
      random_item(add_pct);
    end
  endtask

  initial begin
    fresh_idx = IDX_W'($urandom);
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // empty pops, index extremes and out-of-range appends at reset setting
    send(KIND_POP_FREE, 20'hFFFFF);
    send(KIND_POP_ZEROED, 20'h00000);
    send(KIND_ADD_FREE, 20'h00000);
    send(KIND_ADD_FREE, 20'(FRAMES - 1));
    send(KIND_ADD_FREE, 20'(FRAMES));
    send(KIND_ADD_ZEROED, 20'hFFFFF);
    send(KIND_ADD_ZEROED, 20'h00007);
    send(KIND_POP_ZEROED, 20'h00000);
    send(KIND_POP_ZEROED, 20'h00000);

    // heads popped after the base moved are reported against the new base
    set_lowest(20'hFFFFF);
    send(KIND_POP_FREE, 20'h00000);
    send(KIND_POP_FREE, 20'h00000);
    send(KIND_ADD_FREE, 20'h00000);
    send(KIND_ADD_FREE, 20'h00FFF);
    send(KIND_POP_FREE, 20'h00000);

    // duplicate append across lists: zeroed count floors while a head remains
    send(KIND_ADD_FREE, 20'h00010);
    send(KIND_ADD_ZEROED, 20'h00020);
    send(KIND_ADD_ZEROED, 20'h00010);
    send(KIND_ADD_FREE, 20'h00030);
    repeat (4) send(KIND_POP_ZEROED, 20'h00000);
    repeat (2) send(KIND_POP_FREE, 20'h00000);

    set_lowest(FRAME_W'($urandom));
    random_phase(150, 60, 1'b1);
    set_lowest(20'hFFFFF);
    random_phase(150, 45, 1'b1);
    set_lowest(FRAME_W'($urandom));
    random_phase(150, 50, 1'b1);
    set_lowest(20'h00000);
    idle_on = 1'b0;
    random_phase(150, 55, 1'b0);

    // low entries again under a high base, then drain with pops
    set_lowest(20'h80000);
    for (int i = 0; i < 20; i++) send(KIND_ADD_ZEROED, cur_lowest + FRAME_W'(i));
    for (int i = 0; i < 40; i++) begin
      send($urandom_range(1) ? KIND_POP_ZEROED : KIND_POP_FREE, FRAME_W'($urandom));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
